@@ src/aps_pkg.sv @@
// Shared types and constants for the annealing path swap step unit.
// Depends on nothing; aps_accept and the top level import it.
`default_nettype none
package aps_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_LOAD_XY   = 2'd0;
  localparam logic [1:0] CMD_LOAD_TOUR = 2'd1;
  localparam logic [1:0] CMD_MOVE      = 2'd2;
  localparam logic [1:0] CMD_START     = 2'd3;

  // status codes of a result word
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_MOVE = 2'd1;
  localparam logic [1:0] STAT_FINISHED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_COOLING   = 2'd0;
  localparam logic [1:0] REG_INIT_TEMP = 2'd1;
  localparam logic [1:0] REG_STOP_TEMP = 2'd2;
  localparam logic [1:0] REG_NODES     = 2'd3;

  // reset values of registers and state
  localparam logic [15:0] COOLING_RST   = 16'd62259;
  localparam logic [31:0] INIT_TEMP_RST = 32'd16777216;
  localparam logic [31:0] STOP_TEMP_RST = 32'd1678;
  localparam logic [4:0]  NODES_RST     = 5'd10;

  // ratio saturation (16.0 in Q.16) and number of ratio bits
  localparam int unsigned RATIO_BITS = 21;
  localparam int unsigned DIV_STEPS  = 20;

  // exp(-2^k) in Q0.32 for k = -16 .. 4 (bit k of the Q.16 ratio)
  localparam logic [31:0] EXP_NEG_POW2 [RATIO_BITS] = '{
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040, 32'd4293918848,
    32'd4292870656, 32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
    32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
    32'd2605029347, 32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
    32'd483
  };

  // status returned by the acceptance unit
  typedef struct packed {
    logic done;
    logic accept;
  } aps_acc_res_t;

endpackage
`default_nettype wire

@@ src/aps_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module aps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/aps_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing; no shared items of aps_pkg are used.
`default_nettype none
module aps_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [37:0] radicand_i,
  output logic             done_o,
  output logic      [18:0] root_o
);

  logic [37:0] rad_q, rad_d;
  logic [20:0] rem_q, rem_d;
  logic [18:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [22:0] rem2;
  logic [22:0] trial;
  logic        ge;

  // one restoring step
  always_comb begin
    rem2   = {rem_q, rad_q[37:36]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = (rem2 >= trial);
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 5'd19;
      run_d  = 1'b1;
    end else if (run_q) begin
      rad_d  = {rad_q[35:0], 2'b00};
      rem_d  = ge ? 21'(rem2 - trial) : rem2[20:0];
      root_d = {root_q[17:0], ge};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

@@ src/aps_accept.sv @@
// Metropolis acceptance: ratio diff/T by long division, then exp(-r) by
// a product of table constants, one multiply per cycle. Uses aps_pkg.
`default_nettype none
module aps_accept (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [31:0]          diff_i,
  input  wire logic [31:0]          temp_i,
  input  wire logic [15:0]          rand_u_i,
  output aps_pkg::aps_acc_res_t     res_o
);
  import aps_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EXP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [20:0] ratio_q, ratio_d;
  logic [31:0] acc_q, acc_d;
  logic        one_q, one_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] u_q, u_d;
  logic        done_d, accept_d;
  logic        done_q, accept_q;
  logic [32:0] rem2;
  logic        ge;
  logic [63:0] prod;
  logic [16:0] expq;

  always_comb begin
    rem2     = {rem_q, 1'b0};
    ge       = (rem2 >= {1'b0, den_q});
    prod     = 64'(acc_q) * 64'(EXP_NEG_POW2[cnt_q]) + 64'h8000_0000;
    expq     = one_q ? 17'h10000 : 17'((33'(acc_q) + 33'd32768) >> 16);
    state_d  = state_q;
    rem_d    = rem_q;
    den_d    = den_q;
    ratio_d  = ratio_q;
    acc_d    = acc_q;
    one_d    = one_q;
    cnt_d    = cnt_q;
    u_d      = u_q;
    done_d   = 1'b0;
    accept_d = accept_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          den_d = temp_i;
          u_d   = rand_u_i;
          acc_d = '0;
          one_d = 1'b1;
          // ratio saturates at 16.0, also for a zero temperature
          if ({diff_i, 12'd0} >= {12'd0, temp_i}) begin
            ratio_d = 21'h100000;
            cnt_d   = '0;
            state_d = S_EXP;
          end else begin
            rem_d   = diff_i << 12;
            ratio_d = '0;
            cnt_d   = 5'(DIV_STEPS);
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d   = ge ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
        ratio_d = {ratio_q[19:0], ge};
        cnt_d   = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          cnt_d   = '0;
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        // multiply in the constant of each set ratio bit
        if (ratio_q[cnt_q]) begin
          if (one_q) begin
            acc_d = EXP_NEG_POW2[cnt_q];
          end else begin
            acc_d = prod[63:32];
          end
          one_d = 1'b0;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(RATIO_BITS - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        accept_d = ({1'b0, u_q} < expq);
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      accept_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      accept_q <= accept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    den_q   <= den_d;
    ratio_q <= ratio_d;
    acc_q   <= acc_d;
    one_q   <= one_d;
    u_q     <= u_d;
  end

  assign res_o.done   = done_q;
  assign res_o.accept = accept_q;

endmodule
`default_nettype wire

@@ src/annealing_path_swap_step_unit.sv @@
// Top level: command decode, tour walk sequencer, cooling and result word.
// Uses aps_pkg, aps_ram (coordinates, tour), aps_sqrt and aps_accept.
//
//   channel   handshake                 payload
//   command   start / busy              cmd_i slot_i node_x_i node_y_i node_id_i
//                                       swap_a_i swap_b_i rand_u_i
//   result    result_valid_o (1 cycle)  status_o accepted_o improved_o
//                                       tour_length_o temperature_o finished_o
//   config    cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// A tour walk does per position one tour RAM read, one coordinate RAM read,
// then a bit-serial square root per edge. Loads, start and moves refused
// with a bad or finished status walk once. A valid move walks twice; a
// candidate that is not shorter goes through the acceptance unit, improved or
// accepted moves make two tour writes, and every valid move ends in cooling.
// Reset leaves the RAMs unwritten; temperature is 1.0 and finished is low.
// The result is shown for one cycle; the receiver cannot stall it.
`default_nettype none
module annealing_path_swap_step_unit #(
  parameter int unsigned MAX_NODES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [9:0]  node_x_i,
  input  wire logic [9:0]  node_y_i,
  input  wire logic [3:0]  node_id_i,
  input  wire logic [3:0]  swap_a_i,
  input  wire logic [3:0]  swap_b_i,
  input  wire logic [15:0] rand_u_i,
  output logic             result_valid_o,
  output logic      [1:0]  status_o,
  output logic             accepted_o,
  output logic             improved_o,
  output logic      [23:0] tour_length_o,
  output logic      [31:0] temperature_o,
  output logic             finished_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import aps_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TRD  = 4'd1;
  localparam logic [3:0] ST_CRD  = 4'd2;
  localparam logic [3:0] ST_CWT  = 4'd3;
  localparam logic [3:0] ST_SQ   = 4'd4;
  localparam logic [3:0] ST_PEND = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_WRA  = 4'd7;
  localparam logic [3:0] ST_WRB  = 4'd8;
  localparam logic [3:0] ST_COOL = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  // configuration registers
  logic [15:0] cool_q;
  logic [31:0] init_q, stop_q;
  logic [4:0]  nodes_q;

  // control and payload state
  logic [3:0]    state_q, state_d;
  logic [31:0]   temp_q, temp_d;
  logic          fin_q, fin_d;
  logic          pass_q, pass_d;
  logic          move_q, move_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [3:0]    a_q, a_d, b_q, b_d;
  logic [15:0]   u_q, u_d;
  logic [3:0]    ida_q, ida_d, idb_q, idb_d;
  logic          idok_q, idok_d;
  logic [9:0]    px_q, px_d, py_q, py_d;
  logic [31:0]   sum_q, sum_d, old_q, old_d;
  logic [1:0]    stat_q, stat_d;
  logic          acc_q, acc_d, imp_q, imp_d;

  logic          in_acc;
  logic [CW-1:0] n_w;
  int            ai, bi, ni;
  logic          bad_move;

  // RAM ports
  logic          t_we, c_we;
  logic [AW-1:0] t_waddr, t_raddr, c_waddr, c_raddr;
  logic [3:0]    t_wdata, t_rdata;
  logic [19:0]   c_wdata, c_rdata;

  // arithmetic
  logic [9:0]  cx, cy, dx, dy;
  logic [20:0] dsq;
  logic        sq_start, sq_done;
  logic [18:0] sq_root;
  logic        ac_start;
  aps_acc_res_t ac_res;
  logic [47:0] cool_prod;
  logic [31:0] len_now;

  assign in_acc      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // clamp the node count to 4 .. MAX_NODES
  always_comb begin
    if (nodes_q < 5'd4) begin
      n_w = CW'(4);
    end else if (int'(nodes_q) > int'(MAX_NODES)) begin
      n_w = CW'(MAX_NODES);
    end else begin
      n_w = CW'(nodes_q);
    end
    ai = int'(swap_a_i);
    bi = int'(swap_b_i);
    ni = int'(n_w);
    bad_move = (ai < 1) || (bi < 1) || (ai > ni - 2) || (bi > ni - 2) || (ai == bi);
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_q  <= COOLING_RST;
      init_q  <= INIT_TEMP_RST;
      stop_q  <= STOP_TEMP_RST;
      nodes_q <= NODES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COOLING:   cool_q  <= cfg_data_i[15:0];
        REG_INIT_TEMP: init_q  <= cfg_data_i;
        REG_STOP_TEMP: stop_q  <= cfg_data_i;
        REG_NODES:     nodes_q <= cfg_data_i[4:0];
        default:       cool_q  <= cool_q;
      endcase
    end
  end

  // coordinate RAM: written only from the command port
  assign c_we    = in_acc && (cmd_i == CMD_LOAD_XY) && (int'(slot_i) < int'(MAX_NODES));
  assign c_waddr = AW'(slot_i);
  assign c_wdata = {node_x_i, node_y_i};
  assign c_raddr = AW'(t_rdata);

  // tour RAM: command loads, then swap write-back
  always_comb begin
    t_we    = 1'b0;
    t_waddr = AW'(slot_i);
    t_wdata = node_id_i;
    if (state_q == ST_WRA) begin
      t_we    = 1'b1;
      t_waddr = AW'(a_q);
      t_wdata = idb_q;
    end else if (state_q == ST_WRB) begin
      t_we    = 1'b1;
      t_waddr = AW'(b_q);
      t_wdata = ida_q;
    end else if (in_acc && (cmd_i == CMD_LOAD_TOUR) && (int'(slot_i) < int'(MAX_NODES))) begin
      t_we = 1'b1;
    end
  end

  // candidate walk reads the two swapped positions crosswise
  always_comb begin
    t_raddr = AW'(pos_q);
    if (pass_q && (int'(pos_q) == int'(a_q))) begin
      t_raddr = AW'(b_q);
    end else if (pass_q && (int'(pos_q) == int'(b_q))) begin
      t_raddr = AW'(a_q);
    end
  end

  aps_ram #(.Width(20), .Depth(MAX_NODES)) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  aps_ram #(.Width(4), .Depth(MAX_NODES)) u_tour_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  // edge length datapath
  always_comb begin
    cx  = idok_q ? c_rdata[19:10] : 10'd0;
    cy  = idok_q ? c_rdata[9:0]   : 10'd0;
    dx  = (cx > px_q) ? (cx - px_q) : (px_q - cx);
    dy  = (cy > py_q) ? (cy - py_q) : (py_q - cy);
    dsq = 21'(20'(dx) * 20'(dx)) + 21'(20'(dy) * 20'(dy));
  end

  assign sq_start = (state_q == ST_CWT) && (pos_q != '0);

  aps_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({1'b0, dsq, 16'd0}),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign ac_start = (state_q == ST_PEND) && pass_q && !(sum_q < old_q);

  aps_accept u_accept (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ac_start),
    .diff_i   (sum_q - old_q),
    .temp_i   (temp_q),
    .rand_u_i (u_q),
    .res_o    (ac_res)
  );

  assign cool_prod = 48'(temp_q) * 48'(cool_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    temp_d  = temp_q;
    fin_d   = fin_q;
    pass_d  = pass_q;
    move_d  = move_q;
    pos_d   = pos_q;
    a_d     = a_q;
    b_d     = b_q;
    u_d     = u_q;
    ida_d   = ida_q;
    idb_d   = idb_q;
    idok_d  = idok_q;
    px_d    = px_q;
    py_d    = py_q;
    sum_d   = sum_q;
    old_d   = old_q;
    stat_d  = stat_q;
    acc_d   = acc_q;
    imp_d   = imp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          a_d    = swap_a_i;
          b_d    = swap_b_i;
          u_d    = rand_u_i;
          stat_d = STAT_OK;
          acc_d  = 1'b0;
          imp_d  = 1'b0;
          move_d = 1'b0;
          pass_d = 1'b0;
          pos_d  = '0;
          sum_d  = '0;
          state_d = ST_TRD;
          if (cmd_i == CMD_START) begin
            temp_d = init_q;
            fin_d  = 1'b0;
          end else if (cmd_i == CMD_MOVE) begin
            if (fin_q) begin
              stat_d = STAT_FINISHED;
            end else if (bad_move) begin
              stat_d = STAT_BAD_MOVE;
            end else begin
              move_d = 1'b1;
            end
          end
        end
      end
      ST_TRD: state_d = ST_CRD;
      ST_CRD: begin
        idok_d = (int'(t_rdata) < int'(MAX_NODES));
        if (!pass_q && (int'(pos_q) == int'(a_q))) ida_d = t_rdata;
        if (!pass_q && (int'(pos_q) == int'(b_q))) idb_d = t_rdata;
        state_d = ST_CWT;
      end
      ST_CWT: begin
        px_d = cx;
        py_d = cy;
        if (pos_q == '0) begin
          pos_d   = pos_q + CW'(1);
          state_d = ST_TRD;
        end else begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sq_done) begin
          sum_d = sum_q + 32'(sq_root);
          if (pos_q == n_w - CW'(1)) begin
            state_d = ST_PEND;
          end else begin
            pos_d   = pos_q + CW'(1);
            state_d = ST_TRD;
          end
        end
      end
      ST_PEND: begin
        if (!pass_q) begin
          old_d = sum_q;
          if (move_q) begin
            pass_d  = 1'b1;
            pos_d   = '0;
            sum_d   = '0;
            state_d = ST_TRD;
          end else begin
            state_d = ST_OUT;
          end
        end else if (sum_q < old_q) begin
          acc_d   = 1'b1;
          imp_d   = 1'b1;
          state_d = ST_WRA;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (ac_res.done) begin
          acc_d   = ac_res.accept;
          state_d = ac_res.accept ? ST_WRA : ST_COOL;
        end
      end
      ST_WRA: state_d = ST_WRB;
      ST_WRB: state_d = ST_COOL;
      ST_COOL: begin
        temp_d = cool_prod[47:16];
        if (cool_prod[47:16] < stop_q) fin_d = 1'b1;
        pass_d  = 1'b0;
        state_d = ST_OUT;
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      temp_q  <= INIT_TEMP_RST;
      fin_q   <= 1'b0;
      pass_q  <= 1'b0;
      move_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      temp_q  <= temp_d;
      fin_q   <= fin_d;
      pass_q  <= pass_d;
      move_q  <= move_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    u_q    <= u_d;
    ida_q  <= ida_d;
    idb_q  <= idb_d;
    idok_q <= idok_d;
    px_q   <= px_d;
    py_q   <= py_d;
    sum_q  <= sum_d;
    old_q  <= old_d;
    stat_q <= stat_d;
    acc_q  <= acc_d;
    imp_q  <= imp_d;
  end

  // result word: current tour is the candidate when accepted
  assign len_now        = (move_q && acc_q) ? sum_q : old_q;
  assign result_valid_o = (state_q == ST_OUT);
  assign status_o       = stat_q;
  assign accepted_o     = acc_q;
  assign improved_o     = imp_q;
  assign tour_length_o  = (len_now > 32'hFF_FFFF) ? 24'hFF_FFFF : len_now[23:0];
  assign temperature_o  = temp_q;
  assign finished_o     = fin_q;

  a_single_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_busy_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while idle");

  a_accept_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && accepted_o) |-> (status_o == STAT_OK))
    else $error("accepted move with bad status");

  a_improved_accepted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && improved_o) |-> accepted_o)
    else $error("improved move not accepted");

endmodule
`default_nettype wire
